### rtl/core/lmw_pkg.sv
package lmw_pkg;

	localparam int FRAC_BITS = 16;

	localparam int TF_W = 32;
	localparam int DL_W = 32;
	localparam int LAM_W = 16;
	localparam int MU_W = 32;
	localparam int WF_W = 32;
	localparam int SM_W = 56;
	localparam int OFF_W = 32;
	localparam int QL_W = 16;
	localparam int OUT_W = 32;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 56;

	// Smoothed lengths in Q.16, and the numerator of the term weight.
	localparam int DEN_W = LAM_W + DL_W + 1;
	localparam int M_W = SM_W + TF_W;
	localparam int NUM_W = M_W + 1;
	localparam int POS_W = $clog2(NUM_W);
	localparam int RES_W = POS_W + FRAC_BITS;
	localparam int MANT_W = 32;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// Stage counts of the three pipeline sections.
	localparam int PREP_ST = 3;
	localparam int LOG_ST = 2 + FRAC_BITS;
	localparam int POST_ST = 4;
	localparam int LOG_FIRST = PREP_ST;
	localparam int POST_FIRST = PREP_ST + LOG_ST;
	localparam int NST = PREP_ST + LOG_ST + POST_ST;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAMBDA = 3'd0,
		REG_MU     = 3'd1,
		REG_FACTOR = 3'd2,
		REG_MULT   = 3'd3,
		REG_OFFSET = 3'd4,
		REG_QLEN   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [LAM_W-1:0] lambda;
		logic [MU_W-1:0]  mu;
		logic [WF_W-1:0]  factor;
		logic [SM_W-1:0]  mult;
		logic [OFF_W-1:0] offset;
		logic [QL_W-1:0]  qlen;
	} cfg_t;

	typedef struct packed {
		logic term_go;
		logic den_zero;
	} flg_t;

endpackage

### rtl/core/lmw_if.sv
interface lmw_in_if import lmw_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [TF_W-1:0] term_freq;
	logic [DL_W-1:0] doc_length;

	modport source (output valid, output term_freq, output doc_length, input ready);
	modport sink (input valid, input term_freq, input doc_length, output ready);
endinterface

interface lmw_out_if import lmw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] term_weight;
	logic [OUT_W-1:0] doc_extra;

	modport source (output valid, output term_weight, output doc_extra, input ready);
	modport sink (input valid, input term_weight, input doc_extra, output ready);
endinterface

### rtl/core/lm_two_stage_document_weight.sv
// Two-stage smoothed language-model weight, one posting per beat.
// Input channel post_in carries term_freq and doc_length; output channel
// wt_out carries term_weight and doc_extra (both Q16.16), one result
// beat for each input beat, in order.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user
// must write them only while the pipeline is empty, which the block itself
// does not enforce. Index order is lambda, mu, factor, multiplier, offset,
// query length. Writes to other indexes are dropped.
// Throughput is one posting per clock while wt_out is not stalled. The pipeline
// has 25 register stages: 3 of products and sums, 18 for the log2 units
// (leading-one search, normalize, one squaring multiplier per fraction bit),
// and 4 for the log differences, ln2 scale, weight products and clamp.
// Reset clears all valid bits and loads the default register values.
// When wt_out stalls, the pipeline keeps filling its empty stages and
// drops post_in.ready only once every stage holds a posting.
module lm_two_stage_document_weight import lmw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	lmw_in_if.sink                post_in,
	lmw_out_if.source             wt_out
);

	cfg_t             cfg_q;
	logic [NST-1:0]   en;
	flg_t             flg;
	logic [NUM_W-1:0] num;
	logic [DEN_W-1:0] den;
	logic [DEN_W-1:0] bden;
	logic [RES_W-1:0] ln_n;
	logic [RES_W-1:0] ln_d;
	logic [RES_W-1:0] ln_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lambda <= LAM_W'(45875);
			cfg_q.mu <= MU_W'(512000);
			cfg_q.factor <= WF_W'(65536);
			cfg_q.mult <= '0;
			cfg_q.offset <= '0;
			cfg_q.qlen <= QL_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LAMBDA: cfg_q.lambda <= cfg_wdata[LAM_W-1:0];
				REG_MU:     cfg_q.mu <= cfg_wdata[MU_W-1:0];
				REG_FACTOR: cfg_q.factor <= cfg_wdata[WF_W-1:0];
				REG_MULT:   cfg_q.mult <= cfg_wdata[SM_W-1:0];
				REG_OFFSET: cfg_q.offset <= cfg_wdata[OFF_W-1:0];
				REG_QLEN:   cfg_q.qlen <= cfg_wdata[QL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lmw_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (post_in.valid),
		.tf        (post_in.term_freq),
		.dl        (post_in.doc_length),
		.out_ready (wt_out.ready),
		.en        (en),
		.out_valid (wt_out.valid),
		.flg       (flg)
	);

	assign post_in.ready = en[0];

	lmw_prep u_prep (
		.clk  (clk),
		.en   (en[PREP_ST-1:0]),
		.cfg  (cfg_q),
		.tf   (post_in.term_freq),
		.dl   (post_in.doc_length),
		.num  (num),
		.den  (den),
		.bden (bden)
	);

	lmw_log2 u_log_num (
		.clk (clk),
		.en  (en[LOG_FIRST +: LOG_ST]),
		.val (num),
		.res (ln_n)
	);

	lmw_log2 u_log_den (
		.clk (clk),
		.en  (en[LOG_FIRST +: LOG_ST]),
		.val (NUM_W'(den)),
		.res (ln_d)
	);

	lmw_log2 u_log_bden (
		.clk (clk),
		.en  (en[LOG_FIRST +: LOG_ST]),
		.val (NUM_W'(bden)),
		.res (ln_b)
	);

	lmw_post u_post (
		.clk          (clk),
		.en           (en[POST_FIRST +: POST_ST]),
		.cfg          (cfg_q),
		.flg          (flg),
		.ln_n         (ln_n),
		.ln_d         (ln_d),
		.ln_b         (ln_b),
		.term_weight  (wt_out.term_weight),
		.doc_extra    (wt_out.doc_extra)
	);

endmodule

### rtl/core/lmw_ctl.sv
module lmw_ctl import lmw_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            in_valid,
	input  logic [TF_W-1:0] tf,
	input  logic [DL_W-1:0] dl,
	input  logic            out_ready,
	output logic [NST-1:0]  en,
	output logic            out_valid,
	output flg_t            flg
);

	logic [NST-1:0] vld_q;
	flg_t           flg_s [POST_FIRST];
	flg_t           flg_in;

	// A stage loads when it is empty or when everything after it can move.
	genvar k;
	generate
		for (k = 0; k < NST; k++) begin : g_en
			assign en[k] = !(&vld_q[NST-1:k]) || out_ready;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_comb begin
		flg_in.term_go = (tf != '0) && (cfg.mult != '0);
		flg_in.den_zero = ((cfg.lambda == '0) || (dl == '0)) && (cfg.mu == '0);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			flg_s[0] <= flg_in;
		end
		for (int i = 1; i < POST_FIRST; i++) begin
			if (en[i]) begin
				flg_s[i] <= flg_s[i-1];
			end
		end
	end

	assign out_valid = vld_q[NST-1];
	assign flg = flg_s[POST_FIRST-1];

endmodule

### rtl/core/lmw_prep.sv
module lmw_prep import lmw_pkg::*; (
	input  logic               clk,
	input  logic [PREP_ST-1:0] en,
	input  cfg_t               cfg,
	input  logic [TF_W-1:0]    tf,
	input  logic [DL_W-1:0]    dl,
	output logic [NUM_W-1:0]   num,
	output logic [DEN_W-1:0]   den,
	output logic [DEN_W-1:0]   bden
);

	logic [63:0]                p0_s1;
	logic [SM_W-32+TF_W-1:0]    p1_s1;
	logic [LAM_W+DL_W-1:0]      dp_s1;
	logic [DL_W-1:0]            dl_s1;
	logic [M_W-1:0]             m_s2;
	logic [DEN_W-1:0]           den_s2;
	logic [DEN_W-1:0]           bden_s2;
	logic [NUM_W-1:0]           num_s3;
	logic [DEN_W-1:0]           den_s3;
	logic [DEN_W-1:0]           bden_s3;

	// The 56-bit multiplier is split into a low 32-bit and a high 24-bit product.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			p0_s1 <= cfg.mult[31:0] * tf;
			p1_s1 <= cfg.mult[SM_W-1:32] * tf;
			dp_s1 <= cfg.lambda * dl;
			dl_s1 <= dl;
		end
		if (en[1]) begin
			m_s2 <= M_W'(p0_s1) + {p1_s1, 32'b0};
			den_s2 <= DEN_W'(dp_s1) + DEN_W'({cfg.mu, 8'b0});
			bden_s2 <= DEN_W'({dl_s1, 16'b0}) + DEN_W'({cfg.mu, 8'b0});
		end
		if (en[2]) begin
			num_s3 <= NUM_W'(m_s2) + NUM_W'(den_s2);
			den_s3 <= den_s2;
			bden_s3 <= bden_s2;
		end
	end

	assign num = num_s3;
	assign den = den_s3;
	assign bden = bden_s3;

endmodule

### rtl/core/lmw_log2.sv
module lmw_log2 import lmw_pkg::*; (
	input  logic              clk,
	input  logic [LOG_ST-1:0] en,
	input  logic [NUM_W-1:0]  val,
	output logic [RES_W-1:0]  res
);

	logic [NUM_W-1:0]  val_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [POS_W-1:0]  pos;
	logic [NUM_W-1:0]  norm;
	logic [MANT_W-1:0] mant_s [FRAC_BITS+1];
	logic [RES_W-1:0]  res_s [FRAC_BITS+1];

	always_comb begin
		pos = '0;
		for (int i = 0; i < NUM_W; i++) begin
			if (val[i]) begin
				pos = POS_W'(i);
			end
		end
	end

	// Move the top one to the MSB; bits below bit 0 fill with zeros.
	assign norm = val_s1 << (POS_W'(NUM_W - 1) - pos_s1);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			val_s1 <= val;
			pos_s1 <= pos;
		end
		if (en[1]) begin
			mant_s[0] <= norm[NUM_W-1 -: MANT_W];
			res_s[0] <= RES_W'(pos_s1);
		end
	end

	// One squaring per stage yields one fraction bit.
	genvar k;
	generate
		for (k = 1; k <= FRAC_BITS; k++) begin : g_sq
			logic [2*MANT_W-1:0] sq;
			logic [MANT_W:0]     t;

			assign sq = mant_s[k-1] * mant_s[k-1];
			assign t = sq[2*MANT_W-1:MANT_W-1];

			always_ff @(posedge clk) begin
				if (en[1+k]) begin
					mant_s[k] <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
					res_s[k] <= {res_s[k-1][RES_W-2:0], t[MANT_W]};
				end
			end
		end
	endgenerate

	assign res = res_s[FRAC_BITS];

endmodule

### rtl/core/lmw_post.sv
module lmw_post import lmw_pkg::*; (
	input  logic               clk,
	input  logic [POST_ST-1:0] en,
	input  cfg_t               cfg,
	input  flg_t               flg,
	input  logic [RES_W-1:0]   ln_n,
	input  logic [RES_W-1:0]   ln_d,
	input  logic [RES_W-1:0]   ln_b,
	output logic [OUT_W-1:0]   term_weight,
	output logic [OUT_W-1:0]   doc_extra
);

	localparam int W_W = WF_W + RES_W;
	localparam int Q_W = QL_W + RES_W;
	localparam int MAG_W = Q_W + 16;
	localparam int SUM_W = MAG_W + 1;

	logic [RES_W-1:0]     dt_s1;
	logic [RES_W-1:0]     de_s1;
	logic                 below_s1;
	flg_t                 flg_s1;
	logic [RES_W-1:0]     lnv_s2;
	logic [RES_W-1:0]     lnm_s2;
	logic                 below_s2;
	flg_t                 flg_s2;
	logic [W_W-1:0]       w_s3;
	logic [Q_W-1:0]       q_s3;
	logic                 below_s3;
	flg_t                 flg_s3;
	logic [OUT_W-1:0]     term_s4;
	logic [OUT_W-1:0]     extra_s4;

	logic [RES_W+31:0]    lnv_full;
	logic [RES_W+31:0]    lnm_full;
	logic [W_W-1:0]       wsh;
	logic [MAG_W-1:0]     mag;
	logic [SUM_W-1:0]     sum;
	logic [MAG_W-1:0]     off_ext;
	logic [OUT_W-1:0]     term_nxt;
	logic [OUT_W-1:0]     extra_nxt;

	assign lnv_full = dt_s1 * LN2_Q32;
	assign lnm_full = de_s1 * LN2_Q32;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dt_s1 <= (ln_n > ln_d) ? ln_n - ln_d : '0;
			below_s1 <= ln_d < ln_b;
			de_s1 <= (ln_d < ln_b) ? ln_b - ln_d : ln_d - ln_b;
			flg_s1 <= flg;
		end
		if (en[1]) begin
			lnv_s2 <= lnv_full[RES_W+31:32];
			lnm_s2 <= lnm_full[RES_W+31:32];
			below_s2 <= below_s1;
			flg_s2 <= flg_s1;
		end
		if (en[2]) begin
			w_s3 <= cfg.factor * lnv_s2;
			q_s3 <= cfg.qlen * lnm_s2;
			below_s3 <= below_s2;
			flg_s3 <= flg_s2;
		end
		if (en[3]) begin
			term_s4 <= term_nxt;
			extra_s4 <= extra_nxt;
		end
	end

	always_comb begin
		wsh = w_s3 >> FRAC_BITS;
		mag = MAG_W'({q_s3, 16'b0} >> FRAC_BITS);
		off_ext = MAG_W'(cfg.offset);
		sum = SUM_W'(off_ext) + SUM_W'(mag);

		if (!flg_s3.term_go) begin
			term_nxt = '0;
		end else if (flg_s3.den_zero) begin
			term_nxt = (cfg.factor != '0) ? '1 : '0;
		end else if (|wsh[W_W-1:OUT_W]) begin
			term_nxt = '1;
		end else begin
			term_nxt = wsh[OUT_W-1:0];
		end

		// A smoothed length below the plain one pulls the weight down from the offset.
		if (flg_s3.den_zero) begin
			extra_nxt = '0;
		end else if (below_s3) begin
			extra_nxt = (mag >= off_ext) ? '0 : cfg.offset - mag[OUT_W-1:0];
		end else if (|sum[SUM_W-1:OUT_W]) begin
			extra_nxt = '1;
		end else begin
			extra_nxt = sum[OUT_W-1:0];
		end
	end

	assign term_weight = term_s4;
	assign doc_extra = extra_s4;

endmodule

### rtl/core/lmw_checker.sv
module lmw_checker import lmw_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OUT_W-1:0] term_weight,
	input logic [OUT_W-1:0] doc_extra
);

	// A held result beat keeps its value until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(term_weight)
			&& $stable(doc_extra))
		else $error("result beat changed while stalled");

	// Input backpressure only comes from a full pipeline behind a stalled output.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled output");

	// An input beat offered to a pipeline with no pending result is always taken.
	a_empty_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_valid |-> in_ready)
		else $error("input refused with empty output stage");

	// A clock edge seen in reset leaves the output idle at the next edge.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid during reset");

endmodule

bind lm_two_stage_document_weight lmw_checker u_lmw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (post_in.valid),
	.in_ready     (post_in.ready),
	.out_valid    (wt_out.valid),
	.out_ready    (wt_out.ready),
	.term_weight  (wt_out.term_weight),
	.doc_extra    (wt_out.doc_extra)
);

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lmw_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 12;
	localparam int POSTINGS_PER_PHASE = 130;

	typedef struct {
		logic [TF_W-1:0] tf;
		logic [DL_W-1:0] dl;
	} posting_t;

	typedef struct {
		logic [OUT_W-1:0] term;
		logic [OUT_W-1:0] extra;
	} weight_pair_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	lmw_in_if post_if ();
	lmw_out_if wt_if ();

	lm_two_stage_document_weight u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.post_in(post_if),
		.wt_out(wt_if)
	);

	cfg_t shadow_cfg;
	posting_t pending_postings[$];
	weight_pair_t expected_weights[$];
	int unsigned errors;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned quiet_cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// log2 of a nonzero value in Q.FRAC_BITS, by repeated squaring of the mantissa.
	function automatic logic [63:0] fixed_log2(logic [127:0] v);
		int p;
		logic [127:0] aligned;
		logic [63:0] m;
		logic [63:0] r;
		p = 0;
		for (int i = 0; i < 128; i++)
			if (v[i])
				p = i;
		if (p >= 31)
			aligned = v >> (p - 31);
		else
			aligned = v << (31 - p);
		m = {32'd0, aligned[31:0]};
		r = 64'(p);
		for (int i = 0; i < FRAC_BITS; i++) begin
			m = (m * m) >> 31;
			r = r << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				r = r | 64'd1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] scale_ln2(logic [63:0] diff);
		logic [127:0] prod;
		prod = 128'(diff) * 128'(LN2_Q32);
		return prod[95:32];
	endfunction

	function automatic weight_pair_t smoothed_weights(logic [TF_W-1:0] tf, logic [DL_W-1:0] dl);
		weight_pair_t res;
		logic [63:0] den;
		logic [63:0] bden;
		logic [127:0] num;
		logic [63:0] ln_n;
		logic [63:0] ln_d;
		logic [63:0] lnv;
		logic [63:0] w;
		logic [63:0] la;
		logic [63:0] lb;
		logic [63:0] mag;
		logic [63:0] sum;
		logic below;
		den = 64'(shadow_cfg.lambda) * 64'(dl) + (64'(shadow_cfg.mu) << 8);
		bden = (64'(dl) << 16) + (64'(shadow_cfg.mu) << 8);
		res.term = '0;
		res.extra = '0;
		if (tf != 0 && shadow_cfg.mult != 0) begin
			if (den == 0) begin
				res.term = (shadow_cfg.factor != 0) ? '1 : '0;
			end else begin
				num = 128'(shadow_cfg.mult) * 128'(tf) + 128'(den);
				ln_n = fixed_log2(num);
				ln_d = fixed_log2(128'(den));
				lnv = (ln_n > ln_d) ? scale_ln2(ln_n - ln_d) : 64'd0;
				w = (64'(shadow_cfg.factor) * lnv) >> FRAC_BITS;
				res.term = (w > 64'hFFFF_FFFF) ? '1 : w[31:0];
			end
		end
		if (den != 0) begin
			la = fixed_log2(128'(den));
			lb = fixed_log2(128'(bden));
			below = la < lb;
			mag = ((64'(shadow_cfg.qlen) * scale_ln2(below ? lb - la : la - lb)) << 16)
				>> FRAC_BITS;
			if (below) begin
				res.extra = (mag >= 64'(shadow_cfg.offset)) ? '0
					: 32'(64'(shadow_cfg.offset) - mag);
			end else begin
				sum = 64'(shadow_cfg.offset) + mag;
				res.extra = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] %s: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_LAMBDA: shadow_cfg.lambda = value[LAM_W-1:0];
			REG_MU:     shadow_cfg.mu = value[MU_W-1:0];
			REG_FACTOR: shadow_cfg.factor = value[WF_W-1:0];
			REG_MULT:   shadow_cfg.mult = value[SM_W-1:0];
			REG_OFFSET: shadow_cfg.offset = value[OFF_W-1:0];
			REG_QLEN:   shadow_cfg.qlen = value[QL_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_posting(logic [TF_W-1:0] tf, logic [DL_W-1:0] dl);
		posting_t p;
		p.tf = tf;
		p.dl = dl;
		pending_postings.push_back(p);
	endtask

	// The pipeline is empty once every expected beat has come back.
	task automatic wait_idle();
		while (pending_postings.size() != 0 || post_if.valid || expected_weights.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] wide_random();
		return CFG_DATA_W'({$urandom, $urandom});
	endfunction

	function automatic logic [DL_W-1:0] random_length();
		case ($urandom_range(9))
			0: return ($urandom_range(40) == 0) ? '0 : 32'($urandom_range(1, 10));
			1, 2, 3: return 32'($urandom_range(1, 400));
			4, 5, 6: return 32'($urandom_range(1, 65535));
			7: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [TF_W-1:0] random_freq();
		case ($urandom_range(9))
			0: return '0;
			1, 2, 3, 4: return 32'($urandom_range(1, 20));
			5, 6: return 32'($urandom_range(1, 5000));
			7: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_config();
		case ($urandom_range(3))
			0: write_reg(REG_LAMBDA, '0);
			1: write_reg(REG_LAMBDA, 56'hFFFF);
			default: write_reg(REG_LAMBDA, 56'($urandom_range(65535)));
		endcase
		case ($urandom_range(4))
			0: write_reg(REG_MU, '0);
			1: write_reg(REG_MU, 56'hFFFF_FFFF);
			2: write_reg(REG_MU, 56'($urandom));
			default: write_reg(REG_MU, 56'($urandom_range(1 << 20)));
		endcase
		case ($urandom_range(3))
			0: write_reg(REG_FACTOR, 56'hFFFF_FFFF);
			1: write_reg(REG_FACTOR, 56'($urandom_range(1 << 20)));
			default: write_reg(REG_FACTOR, 56'($urandom));
		endcase
		case ($urandom_range(4))
			0: write_reg(REG_MULT, 56'hFF_FFFF_FFFF_FFFF);
			1: write_reg(REG_MULT, 56'($urandom_range(1 << 24)));
			default: write_reg(REG_MULT, wide_random() >> $urandom_range(55));
		endcase
		case ($urandom_range(3))
			0: write_reg(REG_OFFSET, '0);
			1: write_reg(REG_OFFSET, 56'hFFFF_FFFF);
			default: write_reg(REG_OFFSET, 56'($urandom));
		endcase
		case ($urandom_range(3))
			0: write_reg(REG_QLEN, '0);
			1: write_reg(REG_QLEN, 56'hFFFF);
			default: write_reg(REG_QLEN, 56'($urandom_range(1, 40)));
		endcase
		write_reg(REG_UNUSED, wide_random());
	endtask

	// Driver: a beat leaves the queue when the previous one was taken or none was up.
	always @(posedge clk) begin
		if (arst_n && (!post_if.valid || post_if.ready)) begin
			if (pending_postings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				post_if.valid <= 1'b1;
				post_if.term_freq <= pending_postings[0].tf;
				post_if.doc_length <= pending_postings[0].dl;
				void'(pending_postings.pop_front());
			end else begin
				post_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		wt_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Monitor: predict on accepted input beats, check accepted output beats.
	always @(posedge clk) begin
		weight_pair_t want;
		if (arst_n && post_if.valid && post_if.ready)
			expected_weights.push_back(smoothed_weights(post_if.term_freq,
				post_if.doc_length));
		if (arst_n && wt_if.valid && wt_if.ready) begin
			if (expected_weights.size() == 0) begin
				$display("[%0t] result beat with nothing outstanding", $time);
				errors++;
			end else begin
				want = expected_weights.pop_front();
				if (wt_if.term_weight !== want.term)
					report_mismatch("term_weight", wt_if.term_weight, want.term);
				if (wt_if.doc_extra !== want.extra)
					report_mismatch("doc_extra", wt_if.doc_extra, want.extra);
			end
		end
	end

	always @(posedge clk) begin
		if ((post_if.valid && post_if.ready) || (wt_if.valid && wt_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		errors = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LAMBDA;
		cfg_wdata = '0;
		post_if.valid = 1'b0;
		post_if.term_freq = '0;
		post_if.doc_length = '0;
		wt_if.ready = 1'b0;
		shadow_cfg.lambda = 16'd45875;
		shadow_cfg.mu = 32'd512000;
		shadow_cfg.factor = 32'd65536;
		shadow_cfg.mult = '0;
		shadow_cfg.offset = '0;
		shadow_cfg.qlen = 16'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: zero multiplier, so only the extra weight moves.
		queue_posting(32'd3, 32'd1);
		queue_posting('1, '1);
		queue_posting(32'd7, '0);
		wait_idle();

		write_reg(REG_MULT, 56'd65536 * 56'd300);
		write_reg(REG_OFFSET, 56'd65536 * 56'd20);
		write_reg(REG_QLEN, 56'd3);
		queue_posting('0, 32'd100);
		queue_posting(32'd1, 32'd1);
		queue_posting('1, 32'd1);
		queue_posting(32'd5, '1);
		queue_posting(32'h5555_5555, 32'hAAAA_AAAA);
		queue_posting(32'hAAAA_AAAA, 32'h5555_5555);
		queue_posting(32'd2, 32'd2000);
		wait_idle();

		// No smoothing at all: with lambda and mu zero, every posting gives a zero denominator.
		write_reg(REG_LAMBDA, '0);
		write_reg(REG_MU, '0);
		queue_posting(32'd5, '0);
		queue_posting('0, '0);
		queue_posting(32'd4, 32'd9);
		wait_idle();
		write_reg(REG_FACTOR, '0);
		queue_posting(32'd5, '0);
		queue_posting(32'd4, 32'd9);
		wait_idle();

		// Lambda near one with extremes everywhere else, so sums clamp high.
		write_reg(REG_LAMBDA, 56'hFFFF);
		write_reg(REG_MU, 56'hFFFF_FFFF);
		write_reg(REG_FACTOR, 56'hFFFF_FFFF);
		write_reg(REG_MULT, 56'hFF_FFFF_FFFF_FFFF);
		write_reg(REG_OFFSET, 56'hFFFF_FFFF);
		write_reg(REG_QLEN, 56'hFFFF);
		write_reg(REG_UNUSED, 56'h12_3456);
		queue_posting('1, '1);
		queue_posting(32'd1, 32'd1);
		queue_posting('1, '0);
		queue_posting(32'd1, '1);
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_config();
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 60; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 60; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			for (int n = 0; n < POSTINGS_PER_PHASE; n++)
				queue_posting(random_freq(), random_length());
			wait_idle();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
